// ----- sv/vglb_pkg.sv -----
// ----------------------------------------------------------------------------
// vglb_pkg
// Shared codes for the vector glyph line builder: register indexes,
// configuration widths, attachment modes and register reset values.
// ----------------------------------------------------------------------------
package vglb_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_LEN     = 2'd0;
  localparam logic [1:0] REG_MAX_LEN     = 2'd1;
  localparam logic [1:0] REG_SCALE       = 2'd2;
  localparam logic [1:0] REG_ATTACH_MODE = 2'd3;

  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIdxWidth  = 2;

  // where the line sits relative to the point (unused code acts as start)
  typedef enum logic [1:0] {
    ATTACH_START  = 2'd0,
    ATTACH_CENTRE = 2'd1,
    ATTACH_END    = 2'd2
  } attach_mode_e;

  // reset values of the registers
  localparam logic [31:0] MinLenReset = 32'h0000_0000;
  localparam logic [31:0] MaxLenReset = 32'hFFFF_FFFF;
  localparam logic [31:0] ScaleReset  = 32'h0001_0000;

endpackage

// ----- sv/vector_glyph_line_builder_unit.sv -----
// ----------------------------------------------------------------------------
// vector_glyph_line_builder_unit
// Turns a point and a vector into the two endpoints of a glyph line, with
// length clamping, scaling and saturation, one item per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point and its vector per item, m_axis returns the line
//   start and end per item, exactly one result per input, in order.
//   The cfg port writes min_len, max_len, scale and attach_mode; write only
//   while no item is in flight.
// Throughput: one item per cycle while the receiver keeps up. Pipeline: 8
//   front stages (squares, sum, compare, target and numerator products),
//   COORD_WIDTH root stages (one root bit each), 64 divider stages (one
//   quotient bit each), 2 endpoint stages and the output register.
// Stall: the whole pipeline advances together; an output register plus a
//   skid register absorb a stalled receiver, and s_axis_tready drops only
//   once the skid register holds an item. No item is lost or repeated.
// Reset: registers return to min 0, max all ones, scale 1.0, start mode;
//   all valid bits clear, so the block is empty and ready at once.
// ----------------------------------------------------------------------------
module vector_glyph_line_builder_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [vglb_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [vglb_pkg::CfgDataWidth-1:0]      cfg_data_i,
  // input items
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // point_x, point_y, point_z, vec_x, vec_y, vec_z (lowest first), zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // result items
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (lowest first), zero pad
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata
);
  import vglb_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = ((6*W+7)/8)*8;
  localparam int unsigned H    = W/2;
  localparam int unsigned HH   = W-H;
  localparam int unsigned UW   = W+32;
  localparam int unsigned MG   = 62;
  localparam int unsigned NW   = W+64;
  localparam int unsigned DS   = 64;
  localparam int unsigned SHW  = UW-16;
  localparam int unsigned CAPW = (SHW > MG) ? SHW : MG;
  localparam int unsigned CMPW = (2*W > 64) ? 2*W : 64;
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (W-1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;

  typedef struct packed {
    logic [2:0][W-1:0]  p;
    logic [2:0]         sg;
    logic [2:0][MG-1:0] um;
    logic               clamp;
  } ctx_t;

  // configuration registers
  logic [31:0] min_len_q, max_len_q, scale_q;
  logic [1:0]  attach_q;
  logic [63:0] mn2_q, mx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
      max_len_q <= MaxLenReset;
      scale_q   <= ScaleReset;
      attach_q  <= ATTACH_START;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_LEN:     min_len_q <= cfg_data_i;
        REG_MAX_LEN:     max_len_q <= cfg_data_i;
        REG_SCALE:       scale_q   <= cfg_data_i;
        REG_ATTACH_MODE: attach_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // squared limits, registered from the limit registers
  always_ff @(posedge clk_i) begin
    mn2_q <= 64'(min_len_q) * 64'(min_len_q);
    mx2_q <= 64'(max_len_q) * 64'(max_len_q);
  end

  // global advance: stop only when the skid register is occupied
  logic en;
  logic skid_vld_q, out_vld_q;
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q, vld8_q;
  logic sq_vld_q [W];
  logic dv_vld_q [DS];
  logic vf1_q, vf2_q;

  // stage 1: unpack, magnitude and sign
  logic [2:0][W-1:0] p1_q, mg1_q;
  logic [2:0]        sg1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p1_q[k]  <= s_axis_tdata[k*W +: W];
        sg1_q[k] <= s_axis_tdata[(3+k)*W + W-1];
        mg1_q[k] <= s_axis_tdata[(3+k)*W + W-1] ? (~s_axis_tdata[(3+k)*W +: W]) + 1'b1
                                                : s_axis_tdata[(3+k)*W +: W];
      end
    end
  end

  // stage 2: partial products of squares and of magnitude times scale
  logic [2:0][W-1:0]    p2_q, mg2_q;
  logic [2:0]           sg2_q;
  logic [2:0][2*HH-1:0] hh2_q;
  logic [2:0][W-1:0]    hl2_q;
  logic [2:0][2*H-1:0]  ll2_q;
  logic [2:0][HH+31:0]  sh2_q;
  logic [2:0][H+31:0]   sl2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q  <= p1_q;
      sg2_q <= sg1_q;
      mg2_q <= mg1_q;
      for (int k = 0; k < 3; k++) begin
        hh2_q[k] <= (2*HH)'(mg1_q[k][W-1:H]) * (2*HH)'(mg1_q[k][W-1:H]);
        hl2_q[k] <= W'(mg1_q[k][W-1:H]) * W'(mg1_q[k][H-1:0]);
        ll2_q[k] <= (2*H)'(mg1_q[k][H-1:0]) * (2*H)'(mg1_q[k][H-1:0]);
        sh2_q[k] <= (HH+32)'(mg1_q[k][W-1:H]) * (HH+32)'(scale_q);
        sl2_q[k] <= (H+32)'(mg1_q[k][H-1:0]) * (H+32)'(scale_q);
      end
    end
  end

  // stage 3: assemble squares and scaled magnitudes
  logic [2:0][W-1:0]   p3_q, mg3_q;
  logic [2:0]          sg3_q;
  logic [2:0][2*W-1:0] sq3_q;
  logic [2:0][UW-1:0]  u3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q  <= p2_q;
      sg3_q <= sg2_q;
      mg3_q <= mg2_q;
      for (int k = 0; k < 3; k++) begin
        sq3_q[k] <= ((2*W)'(hh2_q[k]) << (2*H)) + ((2*W)'(hl2_q[k]) << (H+1))
                  + (2*W)'(ll2_q[k]);
        u3_q[k]  <= (UW'(sh2_q[k]) << H) + UW'(sl2_q[k]);
      end
    end
  end

  // stage 4: sum of squares, unclamped magnitude with cap at 2^61
  logic [2:0][W-1:0]  p4_q, mg4_q;
  logic [2:0]         sg4_q;
  logic [2*W-1:0]     s4_q;
  logic [2:0][MG-1:0] um4_q;
  logic [CAPW-1:0]    cap_w;
  assign cap_w = CAPW'(1) << 61;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q  <= p3_q;
      sg4_q <= sg3_q;
      mg4_q <= mg3_q;
      s4_q  <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      for (int k = 0; k < 3; k++) begin
        um4_q[k] <= (CAPW'(u3_q[k][UW-1:16]) > cap_w) ? cap_w[MG-1:0]
                                                     : MG'(CAPW'(u3_q[k][UW-1:16]));
      end
    end
  end

  // stage 5: length compare against the squared limits
  ctx_t              c5_q;
  logic [2:0][W-1:0] mg5_q;
  logic [2*W-1:0]    s5_q;
  logic              selmin5_q;
  logic              lt_min, gt_max;
  assign lt_min = (s4_q != '0) && (CMPW'(s4_q) < CMPW'(mn2_q));
  assign gt_max = CMPW'(s4_q) > CMPW'(mx2_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q.p     <= p4_q;
      c5_q.sg    <= sg4_q;
      c5_q.um    <= um4_q;
      c5_q.clamp <= lt_min || gt_max;
      selmin5_q  <= lt_min;
      mg5_q      <= mg4_q;
      s5_q       <= s4_q;
    end
  end

  // stage 6: target times scale
  ctx_t              c6_q;
  logic [2:0][W-1:0] mg6_q;
  logic [2*W-1:0]    s6_q;
  logic [63:0]       t6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c6_q  <= c5_q;
      mg6_q <= mg5_q;
      s6_q  <= s5_q;
      t6_q  <= 64'(selmin5_q ? min_len_q : max_len_q) * 64'(scale_q);
    end
  end

  // stage 7: numerator partial products
  ctx_t                c7_q;
  logic [2*W-1:0]      s7_q;
  logic [2:0][HH+31:0] phh7_q, phl7_q;
  logic [2:0][H+31:0]  plh7_q, pll7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c7_q <= c6_q;
      s7_q <= s6_q;
      for (int k = 0; k < 3; k++) begin
        phh7_q[k] <= (HH+32)'(mg6_q[k][W-1:H]) * (HH+32)'(t6_q[63:32]);
        phl7_q[k] <= (HH+32)'(mg6_q[k][W-1:H]) * (HH+32)'(t6_q[31:0]);
        plh7_q[k] <= (H+32)'(mg6_q[k][H-1:0]) * (H+32)'(t6_q[63:32]);
        pll7_q[k] <= (H+32)'(mg6_q[k][H-1:0]) * (H+32)'(t6_q[31:0]);
      end
    end
  end

  // stage 8: numerator assembly
  ctx_t               c8_q;
  logic [2*W-1:0]     s8_q;
  logic [2:0][NW-1:0] n8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c8_q <= c7_q;
      s8_q <= s7_q;
      for (int k = 0; k < 3; k++) begin
        n8_q[k] <= (NW'(phh7_q[k]) << (H+32)) + (NW'(phl7_q[k]) << H)
                 + (NW'(plh7_q[k]) << 32) + NW'(pll7_q[k]);
      end
    end
  end

  // front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q, vld8_q} <= '0;
    end else if (en) begin
      vld1_q <= s_axis_tvalid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vld7_q <= vld6_q;
      vld8_q <= vld7_q;
    end
  end

  // square root: one root bit per stage
  ctx_t               sq_c_q    [W];
  logic [2:0][NW-1:0] sq_n_q    [W];
  logic [W:0]         sq_rem_q  [W];
  logic [W-1:0]       sq_root_q [W];
  logic [2*W-1:0]     sq_rad_q  [W];

  for (genvar g = 0; g < W; g++) begin : g_sqrt
    ctx_t               c_in;
    logic [2:0][NW-1:0] n_in;
    logic [W:0]         rem_in;
    logic [W-1:0]       root_in;
    logic [2*W-1:0]     rad_in;
    logic               v_in;
    logic [W+1:0]       rem2, trial;
    logic               ge;

    if (g == 0) begin : g_first
      assign c_in    = c8_q;
      assign n_in    = n8_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = s8_q;
      assign v_in    = vld8_q;
    end else begin : g_next
      assign c_in    = sq_c_q[g-1];
      assign n_in    = sq_n_q[g-1];
      assign rem_in  = sq_rem_q[g-1];
      assign root_in = sq_root_q[g-1];
      assign rad_in  = sq_rad_q[g-1];
      assign v_in    = sq_vld_q[g-1];
    end

    // trial subtract of (root << 2) | 1
    assign rem2  = {rem_in[W-1:0], rad_in[2*W-1:2*W-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_c_q[g]    <= c_in;
        sq_n_q[g]    <= n_in;
        sq_rem_q[g]  <= ge ? (W+1)'(rem2 - trial) : (W+1)'(rem2);
        sq_root_q[g] <= {root_in[W-2:0], ge};
        sq_rad_q[g]  <= rad_in << 2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[g] <= 1'b0;
      end else if (en) begin
        sq_vld_q[g] <= v_in;
      end
    end
  end

  // divider: numerator / root, one quotient bit per stage
  ctx_t              dv_c_q   [DS];
  logic [W-1:0]      dv_l_q   [DS];
  logic [2:0][W-1:0] dv_rem_q [DS];
  logic [2:0][63:0]  dv_num_q [DS];

  for (genvar g = 0; g < DS; g++) begin : g_div
    ctx_t              c_in;
    logic [W-1:0]      l_in;
    logic [2:0][W-1:0] rem_in;
    logic [2:0][63:0]  num_in;
    logic              v_in;
    logic [2:0][W:0]   rem2;
    logic [2:0]        ge;

    if (g == 0) begin : g_first
      assign c_in = sq_c_q[W-1];
      assign l_in = sq_root_q[W-1];
      assign v_in = sq_vld_q[W-1];
      for (genvar k = 0; k < 3; k++) begin : g_ld
        assign rem_in[k] = sq_n_q[W-1][k][NW-1:64];
        assign num_in[k] = sq_n_q[W-1][k][63:0];
      end
    end else begin : g_next
      assign c_in   = dv_c_q[g-1];
      assign l_in   = dv_l_q[g-1];
      assign v_in   = dv_vld_q[g-1];
      assign rem_in = dv_rem_q[g-1];
      assign num_in = dv_num_q[g-1];
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem2[k] = {rem_in[k], num_in[k][63]};
        ge[k]   = rem2[k] >= {1'b0, l_in};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_c_q[g] <= c_in;
        dv_l_q[g] <= l_in;
        for (int k = 0; k < 3; k++) begin
          dv_rem_q[g][k] <= ge[k] ? W'(rem2[k] - {1'b0, l_in}) : W'(rem2[k]);
          dv_num_q[g][k] <= {num_in[k][62:0], ge[k]};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[g] <= 1'b0;
      end else if (en) begin
        dv_vld_q[g] <= v_in;
      end
    end
  end

  // endpoint stage 1: pick magnitude, halve if centred, restore sign
  ctx_t                    cl_w;
  logic [2:0][W-1:0]       pf1_q;
  logic signed [2:0][63:0] w1_q;
  logic [2:0][MG-1:0]      m_w;
  assign cl_w = dv_c_q[DS-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_w[k] = cl_w.clamp ? MG'(dv_num_q[DS-1][k][63:16]) : cl_w.um[k];
      if (attach_q == ATTACH_CENTRE) begin
        m_w[k] = m_w[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pf1_q <= cl_w.p;
      for (int k = 0; k < 3; k++) begin
        w1_q[k] <= cl_w.sg[k] ? -$signed(64'(m_w[k])) : $signed(64'(m_w[k]));
      end
    end
  end

  // endpoint stage 2: exact sums per attachment mode
  logic signed [2:0][63:0] a2_q, b2_q;
  logic signed [63:0]      pe [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pe[k] = 64'($signed(pf1_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        case (attach_q)
          ATTACH_CENTRE: begin
            a2_q[k] <= pe[k] - w1_q[k];
            b2_q[k] <= pe[k] + w1_q[k];
          end
          ATTACH_END: begin
            a2_q[k] <= pe[k] - w1_q[k];
            b2_q[k] <= pe[k];
          end
          default: begin
            a2_q[k] <= pe[k];
            b2_q[k] <= pe[k] + w1_q[k];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
    end else if (en) begin
      vf1_q <= dv_vld_q[DS-1];
      vf2_q <= vf1_q;
    end
  end

  // saturation to the coordinate range and packing
  function automatic logic [W-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > SatHi) r = SatHi;
    if (v < SatLo) r = SatLo;
    return r[W-1:0];
  endfunction

  logic [DW-1:0] res_w;
  always_comb begin
    res_w = '0;
    for (int k = 0; k < 3; k++) begin
      res_w[k*W +: W]     = sat(a2_q[k]);
      res_w[(3+k)*W +: W] = sat(b2_q[k]);
    end
  end

  // output register with skid register behind it
  logic [DW-1:0] out_data_q, skid_data_q;
  logic          pv, out_free;
  assign pv       = vf2_q && en;
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= pv;
      end
    end else if (pv) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_vld_q ? skid_data_q : res_w;
    end else if (pv) begin
      skid_data_q <= res_w;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vector glyph line builder: streams points and
// vectors under several register settings and random idling on both sides,
// predicts each line start and end in 128-bit integer arithmetic and checks
// every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import vglb_pkg::*;

  localparam int unsigned CW = 32;
  localparam int unsigned DW = ((6*CW+7)/8)*8;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = CW + 90;

  // line builder expectations and result checks
  class line_scoreboard;
    logic [DW-1:0] pending_lines[$];
    logic [31:0]   min_len = MinLenReset;
    logic [31:0]   max_len = MaxLenReset;
    logic [31:0]   scale   = ScaleReset;
    logic [1:0]    attach  = ATTACH_START;
    int unsigned   errors  = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MIN_LEN:     min_len = val;
        REG_MAX_LEN:     max_len = val;
        REG_SCALE:       scale   = val;
        REG_ATTACH_MODE: attach  = val[1:0];
      endcase
    endfunction

    function logic [31:0] saturate(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
    endfunction

    function logic [DW-1:0] build_line(logic [DW-1:0] d);
      logic signed [63:0] p[3];
      logic signed [63:0] v[3];
      logic signed [63:0] w[3];
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic [127:0] mag[3];
      logic [127:0] sq;
      logic [127:0] target;
      logic [127:0] fac;
      logic [127:0] den;
      logic [127:0] q;
      logic [127:0] trial;
      logic [63:0]  root;
      logic [DW-1:0] res;
      bit clamp;
      sq = '0;
      res = '0;
      for (int k = 0; k < 3; k++) begin
        p[k] = $signed(d[32*k +: 32]);
        v[k] = $signed(d[32*(k+3) +: 32]);
        mag[k] = {64'd0, (v[k] < 0) ? -v[k] : v[k]};
        sq += mag[k] * mag[k];
      end
      clamp = 0;
      target = '0;
      // the minimum test comes first and wins over the maximum
      if (sq != 0 && sq < {96'd0, min_len} * {96'd0, min_len}) begin
        clamp = 1;
        target = {96'd0, min_len};
      end else if (sq > {96'd0, max_len} * {96'd0, max_len}) begin
        clamp = 1;
        target = {96'd0, max_len};
      end
      fac = {96'd0, scale};
      den = 128'd1 << 16;
      if (clamp) begin
        root = '0;
        for (int i = 63; i >= 0; i--) begin
          trial = {64'd0, root | (64'd1 << i)};
          if (trial * trial <= sq) root = trial[63:0];
        end
        fac = target * {96'd0, scale};
        den = {64'd0, root} << 16;
      end
      for (int k = 0; k < 3; k++) begin
        q = (mag[k] * fac) / den;
        if (q > (128'd1 << 61)) q = 128'd1 << 61;
        if (attach == ATTACH_CENTRE) q = q >> 1;
        w[k] = (v[k] < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
      end
      // unused mode code behaves as line start
      for (int k = 0; k < 3; k++) begin
        if (attach == ATTACH_CENTRE) begin
          a = p[k] - w[k];
          b = p[k] + w[k];
        end else if (attach == ATTACH_END) begin
          a = p[k] - w[k];
          b = p[k];
        end else begin
          a = p[k];
          b = p[k] + w[k];
        end
        res[32*k +: 32]     = saturate(a);
        res[32*(k+3) +: 32] = saturate(b);
      end
      return res;
    endfunction

    function void note_input(logic [DW-1:0] d);
      pending_lines.push_back(build_line(d));
    endfunction

    task report(string what, int unsigned field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s field %0d: got %h want %h", what, field, got, want);
    endtask

    task check_result(logic [DW-1:0] got);
      logic [DW-1:0] want;
      if (pending_lines.size() == 0) begin
        report("unexpected result", 0, got[31:0], 32'd0);
      end else begin
        want = pending_lines.pop_front();
        for (int k = 0; k < 6; k++)
          if (got[32*k +: 32] !== want[32*k +: 32])
            report("line endpoint", k, got[32*k +: 32], want[32*k +: 32]);
      end
    endtask
  endclass

  logic          clk_i = 0;
  logic          rst_ni = 0;
  logic          cfg_we_i = 0;
  logic [1:0]    cfg_idx_i = '0;
  logic [31:0]   cfg_data_i = '0;
  logic          s_axis_tvalid = 0;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 0;
  logic [DW-1:0] m_axis_tdata;

  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 75;
  int unsigned quiet_cycles = 0;
  line_scoreboard lines = new();

  vector_glyph_line_builder_unit #(.COORD_WIDTH(CW)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // result side: check, random ready, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) lines.check_result(m_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task send_item(logic [DW-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    lines.note_input(d);
  endtask

  task drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (lines.pending_lines.size() != 0) @(posedge clk_i);
  endtask

  // one write with the enable dropped after it, so writes never meet in one step
  task write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
    lines.set_reg(idx, val);
  endtask

  task write_all(logic [31:0] mn, logic [31:0] mx, logic [31:0] sc, logic [1:0] md);
    write_reg(REG_MIN_LEN, mn);
    write_reg(REG_MAX_LEN, mx);
    write_reg(REG_SCALE, sc);
    write_reg(REG_ATTACH_MODE, md);
  endtask

  function logic [DW-1:0] pack(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    return {vz, vy, vx, pz, py, px};
  endfunction

  // mostly short vectors, some full range, some zero components
  function logic [31:0] rand_comp();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? $urandom_range(32'h3_FFFF) : -$urandom_range(32'h3_FFFF);
      2: return $urandom_range(1) ? $urandom_range(32'h3FF) : -$urandom_range(32'h3FF);
      default: return $urandom_range(3) == 0 ? 32'd0 : $urandom_range(32'h7F_FFFF);
    endcase
  endfunction

  function logic [31:0] rand_len();
    case ($urandom_range(2))
      0: return $urandom();
      1: return $urandom_range(32'h4_0000);
      default: return $urandom_range(32'h400);
    endcase
  endfunction

  initial begin
    logic [31:0] mn;
    logic [31:0] mx;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset settings, extremes and the zero vector
    send_item(pack(0, 0, 0, 0, 0, 0));
    send_item(pack(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    send_item(pack(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(pack(32'h0001_0000, 0, 0, 32'h0003_0000, 32'h0004_0000, 0));
    drain();
    // stretch short, shorten long, scale 2.0, centred
    write_all(32'h0002_0000, 32'h0004_0000, 32'h0002_0000, ATTACH_CENTRE);
    send_item(pack(0, 0, 0, 32'h0000_0001, 0, 0));
    send_item(pack(0, 0, 0, 0, 0, 0));
    send_item(pack(5, 5, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(pack(0, 0, 0, 32'h0003_0000, 32'h0000_0000, 32'hFFFC_0000));
    drain();
    // maximum below minimum, line ends at point
    write_all(32'h0010_0000, 32'h0000_1000, 32'hFFFF_FFFF, ATTACH_END);
    send_item(pack(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h0000_0100, 0, 32'hFFFF_FF00));
    send_item(pack(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h1234_5678, 0));
    send_item(pack(1, 2, 3, 32'h0020_0000, 32'hFFE0_0000, 32'h0020_0000));
    drain();
    // unused mode code with extreme lengths and zero scale, then full scale
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 2'd3);
    send_item(pack(32'h0001_0000, 0, 0, 32'h8000_0000, 1, 0));
    send_item(pack(0, 0, 0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    drain();
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    send_item(pack(0, 0, 0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_item(pack(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    drain();

    // random phases under changing settings and idling
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 75;
        rx_idle_pct = 19;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      mn = rand_len();
      mx = rand_len();
      if (ph == 0) begin
        mn = MinLenReset;
        mx = MaxLenReset;
      end
      write_all(mn, mx, (ph % 3 == 1) ? $urandom() : $urandom_range(32'h4_0000),
                (ph == 8) ? 2'd3 : 2'(ph % 3));
      for (int n = 0; n < 82; n++)
        send_item(pack($urandom(), $urandom(), $urandom(), rand_comp(), rand_comp(),
                       rand_comp()));
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lines.errors == 0 && lines.pending_lines.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- vector_glyph_line_builder_unit.f -----
sv/vglb_pkg.sv
sv/vector_glyph_line_builder_unit.sv
tb/testbench.sv
